@@ rtl/core/mrsm_pkg.sv @@
package mrsm_pkg;

  localparam int unsigned START_W = 48;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned OFF_W   = 32;
  localparam int unsigned BS_W    = 25;
  localparam int unsigned AM_W    = 4;
  localparam int unsigned KFO_W   = 24;

  localparam int unsigned DW      = 49;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned TAIL_W  = 33;
  localparam int unsigned PER_W   = 25;
  localparam int unsigned FMOD_W  = 39;

  localparam int unsigned CFG_DATA_W = 25;

  localparam logic [BS_W-1:0] BS_MIN   = 25'd512;
  localparam logic [BS_W-1:0] BS_MAX   = 25'd16777216;
  localparam logic [BS_W-1:0] BS_RESET = 25'd32768;
  localparam logic [AM_W-1:0] AM_RESET = 4'd1;

  localparam logic CMD_SPLIT = 1'b0;
  localparam logic CMD_XLAT  = 1'b1;

  typedef enum logic [0:0] {
    REG_BLOCK_SIZE     = 1'b0,
    REG_ACTIVE_MEMBERS = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ALU_DIV = 1'b0,
    ALU_MUL = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FBLK,
    ST_TAIL,
    ST_PER,
    ST_FMOD,
    ST_VP,
    ST_KBS,
    ST_LEN,
    ST_XLAT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [STEP_W-1:0] steps;
  } alu_ctl_t;

  typedef struct packed {
    logic               cmd;
    logic               is_write;
    logic [START_W-1:0] byte_start;
    logic [COUNT_W-1:0] byte_count;
    logic [SLOT_W-1:0]  member_slot;
    logic [OFF_W-1:0]   seg_offset;
  } req_t;

  typedef struct packed {
    logic [START_W-1:0] member_start;
    logic [COUNT_W-1:0] share_length;
    logic               has_share;
    logic [OFF_W-1:0]   buffer_offset;
  } rsp_t;

  typedef struct packed {
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_t;

endpackage

@@ rtl/core/mrsm_if.sv @@
interface mrsm_req_if;
  logic          valid;
  logic          ready;
  mrsm_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrsm_rsp_if;
  logic          valid;
  logic          ready;
  mrsm_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrsm_cfg_if;
  logic          valid;
  logic          ready;
  mrsm_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mirror_read_split_mapper_core.sv @@
// Channel   Direction  Beat contents
// cfg_i     in         register index (block size, active members) and write data
// req_i     in         cmd, is_write, byte_start, byte_count, member_slot, seg_offset
// rsp_o     out        member_start, share_length, has_share, buffer_offset
//
// One shared divide/multiply unit works one bit per cycle. A read split runs seven
// operations; a read with no share stops after the first divide. A translate of a
// read runs one multiply; writes and translates of writes use no unit operation.
// Reset sets block size 32768, one active member and clears the kept split.
// req_i is not ready while an item is in work; a stalled rsp_o holds the block in its
// final state until the waiting beat is taken.
module mirror_read_split_mapper_core #(
  parameter int unsigned MAX_MEMBERS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrsm_cfg_if.sink   cfg_i,
  mrsm_req_if.sink   req_i,
  mrsm_rsp_if.source rsp_o
);

  localparam int unsigned NW      = $clog2(MAX_MEMBERS + 1);
  localparam int unsigned VW      = $clog2(MAX_MEMBERS);
  localparam int unsigned AM_W    = mrsm_pkg::AM_W;
  localparam int unsigned CW      = (NW > AM_W) ? NW : AM_W;
  localparam int unsigned SLW     = (NW > mrsm_pkg::SLOT_W) ? NW : mrsm_pkg::SLOT_W;
  localparam int unsigned DW      = mrsm_pkg::DW;
  localparam int unsigned BS_W    = mrsm_pkg::BS_W;
  localparam int unsigned START_W = mrsm_pkg::START_W;
  localparam int unsigned COUNT_W = mrsm_pkg::COUNT_W;
  localparam int unsigned OFF_W   = mrsm_pkg::OFF_W;
  localparam int unsigned KFO_W   = mrsm_pkg::KFO_W;
  localparam int unsigned TAIL_W  = mrsm_pkg::TAIL_W;
  localparam int unsigned PER_W   = mrsm_pkg::PER_W;
  localparam int unsigned FMOD_W  = mrsm_pkg::FMOD_W;
  localparam int unsigned STEP_W  = mrsm_pkg::STEP_W;

  mrsm_pkg::state_e   state_q, state_d;
  logic               launched_q, launched_d;

  logic [BS_W-1:0]    bs_cfg_q, bs_cfg_d;
  logic [AM_W-1:0]    am_q, am_d;
  logic [BS_W-1:0]    bs;
  logic [NW-1:0]      n;

  logic               kept_write_q, kept_write_d;
  logic [START_W-1:0] kms_q, kms_d;
  logic [START_W-1:0] kfb_q, kfb_d;
  logic [KFO_W-1:0]   kfo_q, kfo_d;

  logic                        cmd_q, cmd_d;
  logic                        wr_q, wr_d;
  logic [START_W-1:0]          start_q, start_d;
  logic [COUNT_W-1:0]          count_q, count_d;
  logic [mrsm_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [OFF_W-1:0]            segoff_q, segoff_d;
  logic [PER_W-1:0]            blocks_q, blocks_d;
  logic [KFO_W-1:0]            end_off_q, end_off_d;
  logic [PER_W-1:0]            per_q, per_d;
  logic [PER_W-1:0]            perp_q, perp_d;
  logic [VW-1:0]               extra_q, extra_d;
  logic [VW-1:0]               v_q, v_d;
  logic [PER_W-1:0]            k_q, k_d;
  logic [START_W-1:0]          mstart_q, mstart_d;
  logic [COUNT_W-1:0]          len_q, len_d;
  logic [OFF_W-1:0]            boff_q, boff_d;

  mrsm_pkg::rsp_t     rsp_q, rsp_d;
  logic               rsp_valid_q, rsp_valid_d;

  mrsm_pkg::alu_ctl_t alu_ctl;
  logic [DW-1:0]      alu_a;
  logic [BS_W-1:0]    alu_b;
  logic               alu_done;
  logic [DW-1:0]      alu_quo;
  logic [BS_W-1:0]    alu_rem;
  logic               arith;

  logic               accept;
  logic               load;
  logic               short_read;
  logic [TAIL_W-1:0]  tail;
  logic [NW-1:0]      fm;
  logic [NW:0]        vt;
  logic [VW-1:0]      v_new;
  logic [VW-1:0]      vmin;
  logic [PER_W-1:0]   blocks_m1;
  logic [NW-1:0]      n_m1;
  logic [VW-1:0]      lastv;
  logic [KFO_W-1:0]   head;
  logic [BS_W-1:0]    tail_trim;
  logic [START_W-1:0] ms_final;

  mrsm_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .quo_o  (alu_quo),
    .rem_o  (alu_rem)
  );

  always_comb begin
    bs = bs_cfg_q;
    if (bs_cfg_q < mrsm_pkg::BS_MIN) begin
      bs = mrsm_pkg::BS_MIN;
    end else if (bs_cfg_q > mrsm_pkg::BS_MAX) begin
      bs = mrsm_pkg::BS_MAX;
    end
  end

  always_comb begin
    if (am_q == '0) begin
      n = NW'(1);
    end else if (CW'(am_q) > CW'(MAX_MEMBERS)) begin
      n = NW'(MAX_MEMBERS);
    end else begin
      n = NW'(am_q);
    end
  end

  assign accept     = req_i.valid && req_i.ready;
  assign load       = (state_q == mrsm_pkg::ST_DONE) && (!rsp_valid_q || rsp_o.ready);
  assign short_read = (count_q == '0) || (SLW'(slot_q) >= SLW'(n));
  assign tail       = TAIL_W'(kfo_q) + TAIL_W'(count_q) - TAIL_W'(1);
  assign fm         = alu_rem[NW-1:0];
  assign vt         = (NW+1)'(n) + (NW+1)'(slot_q) - (NW+1)'(fm);
  assign v_new      = (vt >= (NW+1)'(n)) ? VW'(vt - (NW+1)'(n)) : VW'(vt);
  assign vmin       = (v_q < extra_q) ? v_q : extra_q;
  assign blocks_m1  = blocks_q - PER_W'(1);
  assign n_m1       = n - NW'(1);
  assign lastv      = (blocks_m1 < PER_W'(n_m1)) ? VW'(blocks_m1) : VW'(n_m1);
  assign head       = (v_q == '0) ? kfo_q : '0;
  assign tail_trim  = (v_q == lastv) ? (bs - BS_W'(end_off_q) - BS_W'(1)) : '0;
  assign ms_final   = (len_q == '0 && !wr_q) ? '0 : mstart_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrsm_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.data.cmd == mrsm_pkg::CMD_XLAT) begin
            state_d = kept_write_q ? mrsm_pkg::ST_DONE : mrsm_pkg::ST_XLAT;
          end else begin
            state_d = req_i.data.is_write ? mrsm_pkg::ST_DONE : mrsm_pkg::ST_FBLK;
          end
        end
      end
      mrsm_pkg::ST_FBLK: begin
        if (alu_done) begin
          state_d = short_read ? mrsm_pkg::ST_DONE : mrsm_pkg::ST_TAIL;
        end
      end
      mrsm_pkg::ST_TAIL: if (alu_done) state_d = mrsm_pkg::ST_PER;
      mrsm_pkg::ST_PER:  if (alu_done) state_d = mrsm_pkg::ST_FMOD;
      mrsm_pkg::ST_FMOD: if (alu_done) state_d = mrsm_pkg::ST_VP;
      mrsm_pkg::ST_VP:   if (alu_done) state_d = mrsm_pkg::ST_KBS;
      mrsm_pkg::ST_KBS:  if (alu_done) state_d = mrsm_pkg::ST_LEN;
      mrsm_pkg::ST_LEN:  if (alu_done) state_d = mrsm_pkg::ST_DONE;
      mrsm_pkg::ST_XLAT: if (alu_done) state_d = mrsm_pkg::ST_DONE;
      mrsm_pkg::ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = mrsm_pkg::ST_IDLE;
        end
      end
      default: state_d = mrsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready   = (state_q == mrsm_pkg::ST_IDLE);
    arith         = 1'b1;
    alu_ctl.op    = mrsm_pkg::ALU_DIV;
    alu_ctl.steps = STEP_W'(BS_W);
    alu_a         = '0;
    alu_b         = bs;
    unique case (state_q)
      mrsm_pkg::ST_FBLK: begin
        alu_ctl.steps = STEP_W'(START_W);
        alu_a         = {start_q, {(DW-START_W){1'b0}}};
      end
      mrsm_pkg::ST_TAIL: begin
        alu_ctl.steps = STEP_W'(TAIL_W);
        alu_a         = {tail, {(DW-TAIL_W){1'b0}}};
      end
      mrsm_pkg::ST_PER: begin
        alu_ctl.steps = STEP_W'(PER_W);
        alu_a         = {blocks_q, {(DW-PER_W){1'b0}}};
        alu_b         = BS_W'(n);
      end
      mrsm_pkg::ST_FMOD: begin
        alu_ctl.steps = STEP_W'(FMOD_W);
        alu_a         = {kfb_q[FMOD_W-1:0], {(DW-FMOD_W){1'b0}}};
        alu_b         = BS_W'(n);
      end
      mrsm_pkg::ST_VP: begin
        alu_ctl.op    = mrsm_pkg::ALU_MUL;
        alu_ctl.steps = STEP_W'(VW);
        alu_a         = DW'(per_q);
        alu_b         = {v_q, {(BS_W-VW){1'b0}}};
      end
      mrsm_pkg::ST_KBS: begin
        alu_ctl.op = mrsm_pkg::ALU_MUL;
        alu_a      = DW'(k_q);
      end
      mrsm_pkg::ST_LEN: begin
        alu_ctl.op = mrsm_pkg::ALU_MUL;
        alu_a      = DW'(perp_q);
      end
      mrsm_pkg::ST_XLAT: begin
        alu_ctl.op = mrsm_pkg::ALU_MUL;
        alu_a      = DW'(kfb_q);
      end
      default: arith = 1'b0;
    endcase
    alu_ctl.start = arith && !launched_q;
  end

  assign launched_d = alu_done ? 1'b0 : (alu_ctl.start ? 1'b1 : launched_q);

  assign cfg_i.ready = 1'b1;

  always_comb begin
    bs_cfg_d = bs_cfg_q;
    am_d     = am_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.data.idx)
        mrsm_pkg::REG_BLOCK_SIZE:     bs_cfg_d = cfg_i.data.wdata[BS_W-1:0];
        mrsm_pkg::REG_ACTIVE_MEMBERS: am_d     = cfg_i.data.wdata[AM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    kept_write_d = kept_write_q;
    kms_d        = kms_q;
    kfb_d        = kfb_q;
    kfo_d        = kfo_q;
    cmd_d        = cmd_q;
    wr_d         = wr_q;
    start_d      = start_q;
    count_d      = count_q;
    slot_d       = slot_q;
    segoff_d     = segoff_q;
    blocks_d     = blocks_q;
    end_off_d    = end_off_q;
    per_d        = per_q;
    perp_d       = perp_q;
    extra_d      = extra_q;
    v_d          = v_q;
    k_d          = k_q;
    mstart_d     = mstart_q;
    len_d        = len_q;
    boff_d       = boff_q;
    rsp_d        = rsp_q;
    if (accept) begin
      cmd_d    = req_i.data.cmd;
      wr_d     = req_i.data.is_write;
      start_d  = req_i.data.byte_start;
      count_d  = req_i.data.byte_count;
      slot_d   = req_i.data.member_slot;
      segoff_d = req_i.data.seg_offset;
      if (req_i.data.cmd == mrsm_pkg::CMD_XLAT) begin
        boff_d = req_i.data.seg_offset;
      end else begin
        kept_write_d = req_i.data.is_write;
        mstart_d     = req_i.data.byte_start;
        len_d        = req_i.data.byte_count;
      end
    end
    if (alu_done) begin
      unique case (state_q)
        mrsm_pkg::ST_FBLK: begin
          kfb_d = alu_quo[START_W-1:0];
          kfo_d = alu_rem[KFO_W-1:0];
          if (short_read) begin
            len_d    = '0;
            mstart_d = '0;
          end
        end
        mrsm_pkg::ST_TAIL: begin
          blocks_d  = alu_quo[PER_W-1:0] + PER_W'(1);
          end_off_d = alu_rem[KFO_W-1:0];
        end
        mrsm_pkg::ST_PER: begin
          per_d   = alu_quo[PER_W-1:0];
          extra_d = alu_rem[VW-1:0];
        end
        mrsm_pkg::ST_FMOD: v_d = v_new;
        mrsm_pkg::ST_VP: begin
          k_d    = alu_quo[PER_W-1:0] + PER_W'(vmin);
          perp_d = per_q + PER_W'(v_q < extra_q);
        end
        mrsm_pkg::ST_KBS: begin
          mstart_d = ((v_q == '0) ? start_q : start_q - START_W'(kfo_q))
                     + alu_quo[START_W-1:0];
        end
        mrsm_pkg::ST_LEN: begin
          len_d = alu_quo[COUNT_W-1:0] - COUNT_W'(head) - COUNT_W'(tail_trim);
        end
        mrsm_pkg::ST_XLAT: begin
          boff_d = kms_q[OFF_W-1:0] + segoff_q - alu_quo[OFF_W-1:0] - OFF_W'(kfo_q);
        end
        default: ;
      endcase
    end
    if (load) begin
      if (cmd_q == mrsm_pkg::CMD_XLAT) begin
        rsp_d.member_start  = kms_q;
        rsp_d.share_length  = '0;
        rsp_d.has_share     = 1'b0;
        rsp_d.buffer_offset = boff_q;
      end else begin
        rsp_d.member_start  = ms_final;
        rsp_d.share_length  = len_q;
        rsp_d.has_share     = (len_q != '0);
        rsp_d.buffer_offset = '0;
        kms_d               = (len_q == '0) ? '0 : ms_final;
      end
    end
  end

  assign rsp_valid_d = load ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mrsm_pkg::ST_IDLE;
      launched_q   <= 1'b0;
      rsp_valid_q  <= 1'b0;
      bs_cfg_q     <= mrsm_pkg::BS_RESET;
      am_q         <= mrsm_pkg::AM_RESET;
      kept_write_q <= 1'b0;
      kms_q        <= '0;
      kfb_q        <= '0;
      kfo_q        <= '0;
    end else begin
      state_q      <= state_d;
      launched_q   <= launched_d;
      rsp_valid_q  <= rsp_valid_d;
      bs_cfg_q     <= bs_cfg_d;
      am_q         <= am_d;
      kept_write_q <= kept_write_d;
      kms_q        <= kms_d;
      kfb_q        <= kfb_d;
      kfo_q        <= kfo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    wr_q      <= wr_d;
    start_q   <= start_d;
    count_q   <= count_d;
    slot_q    <= slot_d;
    segoff_q  <= segoff_d;
    blocks_q  <= blocks_d;
    end_off_q <= end_off_d;
    per_q     <= per_d;
    perp_q    <= perp_d;
    extra_q   <= extra_d;
    v_q       <= v_d;
    k_q       <= k_d;
    mstart_q  <= mstart_d;
    len_q     <= len_d;
    boff_q    <= boff_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("A new beat was offered ready right after an accept.");

  a_share_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.data.has_share == (rsp_o.data.share_length != '0)))
    else $error("The share flag disagrees with the share length.");

  a_done_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> launched_q)
    else $error("The shared unit finished an operation that was never launched.");

endmodule

@@ rtl/core/mrsm_alu.sv @@
module mrsm_alu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mrsm_pkg::alu_ctl_t           ctl_i,
  input  logic [mrsm_pkg::DW-1:0]      a_i,
  input  logic [mrsm_pkg::BS_W-1:0]    b_i,
  output logic                         done_o,
  output logic [mrsm_pkg::DW-1:0]      quo_o,
  output logic [mrsm_pkg::BS_W-1:0]    rem_o
);

  localparam int unsigned DW = mrsm_pkg::DW;
  localparam int unsigned RW = mrsm_pkg::BS_W;
  localparam int unsigned SW = mrsm_pkg::STEP_W;

  // Division is restoring, one quotient bit per cycle, dividend taken MSB first.
  // Multiplication is shift-add, one multiplier bit per cycle, MSB first.
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SW-1:0]     cnt_q, cnt_d;
  mrsm_pkg::alu_op_e op_q, op_d;
  logic [DW-1:0]     x_q, x_d;
  logic [RW-1:0]     y_q, y_d;
  logic [DW-1:0]     acc_q, acc_d;
  logic [RW-1:0]     rem_q, rem_d;

  logic [RW:0]       shin;
  logic [RW:0]       diff;
  logic              ge;
  logic [DW-1:0]     macc;

  assign shin = {rem_q, x_q[DW-1]};
  assign ge   = shin >= {1'b0, y_q};
  assign diff = shin - {1'b0, y_q};
  assign macc = {acc_q[DW-2:0], 1'b0} + (y_q[RW-1] ? x_q : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      op_d   = ctl_i.op;
      cnt_d  = ctl_i.steps;
      x_d    = a_i;
      y_d    = b_i;
      acc_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      if (op_q == mrsm_pkg::ALU_DIV) begin
        rem_d = ge ? diff[RW-1:0] : shin[RW-1:0];
        acc_d = {acc_q[DW-2:0], ge};
        x_d   = {x_q[DW-2:0], 1'b0};
      end else begin
        acc_d = macc;
        y_d   = {y_q[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= mrsm_pkg::ALU_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;
  assign rem_o  = rem_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> busy_q)
    else $error("Unit did not go busy after a start.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("Unit flagged done while still busy.");

  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !ctl_i.start && cnt_q == SW'(1)) |=> done_q)
    else $error("Unit missed done after its last step.");

endmodule
